/* rtl/k_transaction_max_profit_dp_assert.svh */
// assertion macros used by the checker file of the profit block
// depends on: nothing; callers provide clk_i and rst_ni in scope
`ifndef K_TRANSACTION_MAX_PROFIT_DP_ASSERT_SVH
`define K_TRANSACTION_MAX_PROFIT_DP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define KMP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kmp assertion failed");

// next-cycle implication, disabled during reset
`define KMP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kmp assertion failed");

`endif

/* rtl/kmp_pkg.sv */
// types, constants and helpers for the k-transaction profit block
// depends on: nothing
package kmp_pkg;

  localparam int unsigned PriceW  = 16;
  localparam int unsigned ValW    = 34;
  localparam int unsigned ProfitW = 32;
  localparam int unsigned CfgW    = 5;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  localparam logic [CfgW-1:0] MaxTradesRst = 5'd2;
  // word index of the max_trades register
  localparam logic RegMaxTrades = 1'b0;

  typedef logic signed [ValW-1:0] val_t;

  // per-cell control from the top level
  typedef struct packed {
    logic en;     // an item is taken this cycle
    logic start;  // the item opens a new sequence
  } cell_ctrl_t;

  // clamp a 35-bit sum to the signed 34-bit range
  function automatic val_t sat_val(input logic signed [ValW:0] v);
    val_t r;
    if (v[ValW] != v[ValW-1]) begin
      r = v[ValW] ? {1'b1, {(ValW-1){1'b0}}} : {1'b0, {(ValW-1){1'b1}}};
    end else begin
      r = v[ValW-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/kmp_cell.sv */
// one budget cell: keeps hold and flat values for one transaction count
// depends on: kmp_pkg
module kmp_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  kmp_pkg::cell_ctrl_t              ctrl_i,
  input  logic [kmp_pkg::PriceW-1:0]       price_i,
  input  kmp_pkg::val_t                    prev_flat_i,
  output kmp_pkg::val_t                    flat_o
);

  kmp_pkg::val_t hold_q, hold_d;
  kmp_pkg::val_t flat_q, flat_d;
  logic signed [kmp_pkg::ValW:0] buy_w, sell_w;
  kmp_pkg::val_t buy_s, sell_s;

  // candidate values from the neighbor's old flat and own old hold
  assign buy_w  = {prev_flat_i[kmp_pkg::ValW-1], prev_flat_i}
                - {{(kmp_pkg::ValW+1-kmp_pkg::PriceW){1'b0}}, price_i};
  assign sell_w = {hold_q[kmp_pkg::ValW-1], hold_q}
                + {{(kmp_pkg::ValW+1-kmp_pkg::PriceW){1'b0}}, price_i};
  assign buy_s  = kmp_pkg::sat_val(buy_w);
  assign sell_s = kmp_pkg::sat_val(sell_w);

  // first price seeds the cell, later prices take the better option
  always_comb begin
    hold_d = hold_q;
    flat_d = flat_q;
    if (ctrl_i.en) begin
      if (ctrl_i.start) begin
        hold_d = kmp_pkg::ValW'(0) - {{(kmp_pkg::ValW-kmp_pkg::PriceW){1'b0}}, price_i};
        flat_d = '0;
      end else begin
        hold_d = (buy_s > hold_q) ? buy_s : hold_q;
        flat_d = (sell_s > flat_q) ? sell_s : flat_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
      flat_q <= '0;
    end else begin
      hold_q <= hold_d;
      flat_q <= flat_d;
    end
  end

  assign flat_o = flat_q;

endmodule

/* rtl/k_transaction_max_profit_dp.sv */
// pipeline: an input item updates the cell registers, then the budget select is registered as the result item
// throughput: one price per cycle unless the result stream backs up; all budget cells update in the same cycle
// backpressure: at most one item waits between the cells and the output register
// reset: async active low; max_trades returns to 2, the next price opens a sequence
// top level: chain of budget cells, output select and an apb register port
// depends on: kmp_pkg, kmp_cell
module k_transaction_max_profit_dp #(
  parameter int unsigned MAX_TRADES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input stream
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [15:0]                  s_axis_tdata_i,   // [15:0] price
  input  logic                         s_axis_tlast_i,
  // result stream
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [31:0]                  m_axis_tdata_o,   // [31:0] profit
  output logic                         m_axis_tlast_o,
  // configuration port
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [kmp_pkg::AddrW-1:0]    paddr_i,
  input  logic [kmp_pkg::DataW-1:0]    pwdata_i,
  output logic [kmp_pkg::DataW-1:0]    prdata_o,
  output logic                         pready_o
);

  localparam int unsigned SelW = $clog2(MAX_TRADES + 1);
  localparam int unsigned KW   = ($clog2(MAX_TRADES + 1) > kmp_pkg::CfgW)
                               ? $clog2(MAX_TRADES + 1) : kmp_pkg::CfgW;
  localparam logic [KW-1:0] KMax = KW'(MAX_TRADES);

  logic [kmp_pkg::CfgW-1:0] max_trades_q, max_trades_d;
  logic first_q, first_d;
  logic pend_q, pend_d;
  logic pend_last_q, pend_last_d;
  logic out_v_q, out_v_d;
  logic out_last_q, out_last_d;
  logic [kmp_pkg::ProfitW-1:0] profit_q, profit_d;
  logic in_acc, out_free, cfg_wr;
  kmp_pkg::cell_ctrl_t ctrl;
  kmp_pkg::val_t flat_w [MAX_TRADES+1];
  kmp_pkg::val_t sel_w;
  logic [KW-1:0] k_w, k_ext;
  logic [SelW-1:0] sel_idx;

  // handshake: cells move only when the waiting slot is empty or can drain
  assign out_free        = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = !pend_q || out_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign ctrl.en    = in_acc;
  assign ctrl.start = first_q;

  // chain of budget cells, budget zero reads as flat zero
  assign flat_w[0] = '0;
  for (genvar j = 0; j < MAX_TRADES; j++) begin : g_cell
    kmp_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .price_i     (s_axis_tdata_i),
      .prev_flat_i (flat_w[j]),
      .flat_o      (flat_w[j+1])
    );
  end

  // budget select, clamped to the number of cells
  assign k_ext   = KW'(max_trades_q);
  assign k_w     = (k_ext > KMax) ? KMax : k_ext;
  assign sel_idx = SelW'(k_w);
  assign sel_w   = flat_w[sel_idx];

  // profit saturation to the unsigned output range
  always_comb begin
    if (k_w == '0 || sel_w[kmp_pkg::ValW-1]) begin
      profit_d = '0;
    end else if (sel_w[kmp_pkg::ValW-2:kmp_pkg::ProfitW] != '0) begin
      profit_d = '1;
    end else begin
      profit_d = sel_w[kmp_pkg::ProfitW-1:0];
    end
  end

  // sequence and pipeline control
  always_comb begin
    first_d     = first_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    out_v_d     = out_v_q;
    out_last_d  = out_last_q;
    if (out_free) begin
      out_v_d    = pend_q;
      out_last_d = pend_last_q;
      pend_d     = 1'b0;
    end
    if (in_acc) begin
      first_d     = s_axis_tlast_i;
      pend_d      = 1'b1;
      pend_last_d = s_axis_tlast_i;
    end
  end

  // configuration write
  assign cfg_wr       = psel_i && penable_i && pwrite_i && pready_o;
  assign max_trades_d = (cfg_wr && paddr_i[2] == kmp_pkg::RegMaxTrades)
                      ? pwdata_i[kmp_pkg::CfgW-1:0] : max_trades_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_trades_q <= kmp_pkg::MaxTradesRst;
      first_q      <= 1'b1;
      pend_q       <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      max_trades_q <= max_trades_d;
      first_q      <= first_d;
      pend_q       <= pend_d;
      out_v_q      <= out_v_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    pend_last_q <= pend_last_d;
    out_last_q  <= out_last_d;
    if (out_free && pend_q) begin
      profit_q <= profit_d;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = profit_q;
  assign m_axis_tlast_o  = out_last_q;

  // register readback
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == kmp_pkg::RegMaxTrades)
                  ? {{(kmp_pkg::DataW-kmp_pkg::CfgW){1'b0}}, max_trades_q} : '0;

endmodule

/* rtl/kmp_checker.sv */
// port-level checks for the profit block, bound to the top level
// depends on: kmp_pkg, k_transaction_max_profit_dp_assert.svh
`include "k_transaction_max_profit_dp_assert.svh"

module kmp_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  input  logic [31:0]                  m_axis_tdata_o,
  input  logic                         m_axis_tlast_o,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [kmp_pkg::AddrW-1:0]    paddr_i,
  input  logic [kmp_pkg::DataW-1:0]    pwdata_i,
  input  logic [kmp_pkg::DataW-1:0]    prdata_o,
  input  logic                         pready_o
);

  logic                     out_stall;
  logic [32:0]              out_word;
  logic                     wr_budget;
  logic                     rd_budget;
  logic [kmp_pkg::CfgW-1:0] rd_val;
  logic [kmp_pkg::CfgW-1:0] wr_val;

  // helper terms for the checks below
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_word  = {m_axis_tlast_o, m_axis_tdata_o};
  assign rd_budget = (paddr_i[2] == kmp_pkg::RegMaxTrades);
  assign wr_budget = psel_i && penable_i && pwrite_i && pready_o && rd_budget;
  assign rd_val    = prdata_o[kmp_pkg::CfgW-1:0];
  assign wr_val    = pwdata_i[kmp_pkg::CfgW-1:0];

  // stalled result item holds
  `KMP_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid_o && $stable(out_word))

  // no wait states on the register port
  `KMP_ASSERT_IMPL(a_pready, 1'b1, pready_o)

  // budget register reads back only its five bits
  `KMP_ASSERT_IMPL(a_rd_upper, 1'b1, prdata_o[kmp_pkg::DataW-1:kmp_pkg::CfgW] == '0)

  // a write to the budget register is visible on the next read
  `KMP_ASSERT_NEXT(a_rd_back, wr_budget, !rd_budget || rd_val == $past(wr_val))

endmodule

bind k_transaction_max_profit_dp kmp_checker u_kmp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .psel_i          (psel_i),
  .penable_i       (penable_i),
  .pwrite_i        (pwrite_i),
  .paddr_i         (paddr_i),
  .pwdata_i        (pwdata_i),
  .prdata_o        (prdata_o),
  .pready_o        (pready_o)
);
